// ===== hdl/bu2x_pkg.sv =====
// shared types and constants for the bilinear 2x upscaler
// no dependencies; imported by every module of the block
package bu2x_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 768;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // which of the up to four blocks a pixel completes
    typedef enum logic [1:0] {
        BLK_ABOVE        = 2'd0,
        BLK_ABOVE_BORDER = 2'd1,
        BLK_LAST         = 2'd2,
        BLK_CORNER       = 2'd3
    } blk_t;

    typedef struct packed {
        logic row_up;
        logic row_last;
        logic col_left;
        logic col_last;
    } pos_ctl_t;

endpackage

// ===== hdl/bu2x_line_ram.sv =====
// line store: one row of source pixels, single port, read-first
// depends on bu2x_pkg
module bu2x_line_ram #(
    parameter int DEPTH = bu2x_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [AW-1:0]              addr,
    input  logic [bu2x_pkg::PIX_W-1:0] wdata,
    output logic [bu2x_pkg::PIX_W-1:0] rdata
);
    import bu2x_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // read returns the old entry, the new pixel is written at the same edge
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bu2x_emit.sv =====
// holds one pixel, steps through the blocks it completes and blends them
// into the output register; depends on bu2x_pkg
module bu2x_emit #(
    parameter int COL_W  = 10,
    parameter int DATA_W = 56
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic                       load,
    output logic                       item_ready,
    input  logic [bu2x_pkg::PIX_W-1:0] in_pixel,
    input  logic [COL_W-1:0]           in_col,
    input  logic [bu2x_pkg::ROW_W-1:0] in_row,
    input  bu2x_pkg::pos_ctl_t         in_ctl,
    input  logic [bu2x_pkg::PIX_W-1:0] above,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [DATA_W-1:0]          m_tdata,
    output logic                       m_tlast
);
    import bu2x_pkg::*;

    localparam int USED_W = 4 * PIX_W + COL_W + ROW_W;

    logic             hold_valid_reg;
    logic [3:0]       mask_reg, mask_next, mask_load, pick_oh;
    logic [PIX_W-1:0] pix_reg, left_reg, ul_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             col_last_reg;
    blk_t             pick;
    logic             out_load, retire;
    logic [PIX_W-1:0] p, r, d, q;
    logic [COL_W-1:0] b_col;
    logic [ROW_W-1:0] b_row;
    logic [PIX_W:0]   sum_h, sum_v;
    logic [PIX_W+1:0] sum_4;
    logic             out_valid_reg, out_last_reg;
    logic [USED_W-1:0] out_data_reg;

    assign mask_load = {in_ctl.row_last & in_ctl.col_last,
                        in_ctl.row_last & in_ctl.col_left,
                        in_ctl.row_up & in_ctl.col_last,
                        in_ctl.row_up & in_ctl.col_left};

    always_comb
    begin
        if (mask_reg[0])
            pick = BLK_ABOVE;
        else if (mask_reg[1])
            pick = BLK_ABOVE_BORDER;
        else if (mask_reg[2])
            pick = BLK_LAST;
        else
            pick = BLK_CORNER;
        pick_oh   = 4'b0001 << pick;
        mask_next = mask_reg & ~pick_oh;
    end

    assign out_load   = hold_valid_reg && (mask_reg != 4'd0) && (!out_valid_reg || m_tready);
    assign retire     = hold_valid_reg && ((mask_reg == 4'd0) || (out_load && mask_next == 4'd0));
    assign item_ready = !hold_valid_reg || retire;

    always_comb
    begin
        unique case (pick)
            BLK_ABOVE:
            begin
                p = ul_reg;   r = above;    d = left_reg; q = pix_reg;
                b_col = col_reg - COL_W'(1); b_row = row_reg - ROW_W'(1);
            end
            BLK_ABOVE_BORDER:
            begin
                p = above;    r = above;    d = pix_reg;  q = pix_reg;
                b_col = col_reg;             b_row = row_reg - ROW_W'(1);
            end
            BLK_LAST:
            begin
                p = left_reg; r = pix_reg;  d = left_reg; q = pix_reg;
                b_col = col_reg - COL_W'(1); b_row = row_reg;
            end
            default:
            begin
                p = pix_reg;  r = pix_reg;  d = pix_reg;  q = pix_reg;
                b_col = col_reg;             b_row = row_reg;
            end
        endcase
        sum_h = {1'b0, p} + {1'b0, r} + (PIX_W+1)'(1);
        sum_v = {1'b0, p} + {1'b0, d} + (PIX_W+1)'(1);
        sum_4 = {2'b00, p} + {2'b00, r} + {2'b00, d} + {2'b00, q} + (PIX_W+2)'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mask_reg       <= 4'd0;
            left_reg       <= '0;
            ul_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // neighbors of the next pixel come from the one leaving
            if (restart)
            begin
                left_reg <= '0;
                ul_reg   <= '0;
            end
            else if (retire)
            begin
                left_reg <= col_last_reg ? '0 : pix_reg;
                ul_reg   <= col_last_reg ? '0 : above;
            end
            if (load)
            begin
                hold_valid_reg <= 1'b1;
                mask_reg       <= mask_load;
            end
            else if (retire)
            begin
                hold_valid_reg <= 1'b0;
                mask_reg       <= 4'd0;
            end
            else if (out_load)
                mask_reg <= mask_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg      <= in_pixel;
            col_reg      <= in_col;
            row_reg      <= in_row;
            col_last_reg <= in_ctl.col_last;
        end
        if (out_load)
        begin
            out_data_reg <= {b_row, b_col, sum_4[PIX_W+1:2], sum_v[PIX_W:1],
                             sum_h[PIX_W:1], p};
            out_last_reg <= (mask_next == 4'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W - USED_W){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/bilinear_upscale_2x.sv =====
// top level of the bilinear 2x upscaler: counters, configuration, line store
// depends on bu2x_pkg, bu2x_line_ram and bu2x_emit
//
// usage:
//   s_* takes one 8-bit source pixel per item in raster order.
//   m_* gives one 2x2 output block per item; m_tlast marks the last block
//   caused by a source pixel. A pixel causes no block in the first column, nor
//   on the first row unless it is the last; otherwise one block per pixel, two at a row end;
//   on the last row two per pixel, four at the last pixel of the frame.
//   cfg_* writes image_width (index 0) or image_height (index 1) and
//   restarts the frame; write only while the block is idle.
// path: the pixel completing a block passes the line store read, then the
//   blend register, which drives m_tdata.
// throughput: one pixel per cycle while m_tready is high and each pixel causes
//   at most one block; a pixel with more than one block holds the blend stage
//   until all its blocks are out, so row ends and the last row run at one block per cycle.
// reset: counters and neighbor registers clear, width 1024 (clamped to
//   MAX_WIDTH), height 768; the line store is not cleared, and the first row
//   writes it while its reads of the old entries go unused.
// stall: a held m_tready freezes the output register and the blend stage,
//   and s_tready falls once the blend stage holds a pixel it cannot retire.
module bilinear_upscale_2x #(
    parameter int MAX_WIDTH = bu2x_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int DATA_W    = ((4 * bu2x_pkg::PIX_W + COL_W + bu2x_pkg::ROW_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bu2x_pkg::PIX_W-1:0]      s_tdata,   // pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // top_left, top_right, bottom_left, bottom_right, block_col, block_row
    output logic [DATA_W-1:0]               m_tdata,
    output logic                            m_tlast,   // last_in_run
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  bu2x_pkg::cfg_reg_t              cfg_index,
    input  logic [bu2x_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bu2x_pkg::*;

    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(W_RST - 1);
    localparam logic [COL_W-1:0] W_LAST_MAX = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(HEIGHT_RESET - 1);
    localparam logic [ROW_W-1:0] H_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next, w_last_reg, w_last_next;
    logic [ROW_W-1:0] row_reg, row_next, h_last_reg, h_last_next;
    logic [CFG_WIDTH_W-1:0]  cfg_w;
    logic [CFG_HEIGHT_W-1:0] cfg_h;
    logic             s_accept, cfg_accept, item_ready;
    pos_ctl_t         ctl;
    logic [PIX_W-1:0] above;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = item_ready;
    assign s_accept   = s_tvalid && s_tready;

    assign cfg_w = cfg_data[CFG_WIDTH_W-1:0];
    assign cfg_h = cfg_data[CFG_HEIGHT_W-1:0];

    assign ctl.row_up   = (row_reg != '0);
    assign ctl.row_last = (row_reg == h_last_reg);
    assign ctl.col_left = (col_reg != '0);
    assign ctl.col_last = (col_reg == w_last_reg);

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (32'(cfg_w) > 32'(MAX_WIDTH))
                        w_last_next = W_LAST_MAX;
                    else if (cfg_w == '0)
                        w_last_next = '0;
                    else
                        w_last_next = COL_W'(cfg_w - CFG_WIDTH_W'(1));
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (32'(cfg_h) > 32'(MAX_HEIGHT))
                        h_last_next = H_LAST_MAX;
                    else if (cfg_h == '0)
                        h_last_next = '0;
                    else
                        h_last_next = ROW_W'(cfg_h - CFG_HEIGHT_W'(1));
                end
                default:
                begin
                    w_last_next = w_last_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_accept)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (s_accept)
        begin
            if (ctl.col_last)
            begin
                col_next = '0;
                row_next = ctl.row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
                col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            w_last_reg <= W_LAST_RST;
            h_last_reg <= H_LAST_RST;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

    bu2x_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_ram (
        .clk   (clk),
        .en    (s_accept),
        .addr  (col_reg),
        .wdata (s_tdata),
        .rdata (above)
    );

    bu2x_emit #(
        .COL_W  (COL_W),
        .DATA_W (DATA_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_accept),
        .load       (s_accept),
        .item_ready (item_ready),
        .in_pixel   (s_tdata),
        .in_col     (col_reg),
        .in_row     (row_reg),
        .in_ctl     (ctl),
        .above      (above),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter beyond image width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last_reg)
        else $error("row counter beyond image height");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !cfg_accept && ctl.col_last && ctl.row_last)
        |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at frame end");

endmodule
